/* rtl/core/tsp_pkg.sv */
// Package for the closed-tour length and fitness unit.
// Holds payload structs, the controller state type and the command/status structs.
// No dependencies.
package tsp_pkg;

	localparam int unsigned CITY_BITS = 8;
	// Coordinate width, fixed at two 16-bit values per city.
	localparam int unsigned IN_COORD_BITS = 16;
	localparam int unsigned LEN_BITS = 33;
	localparam int unsigned FIT_BITS = 40;
	localparam int unsigned IDX_BITS = 16;
	// Squared distance is below 2^33, shifted by 16 gives a 49-bit radicand.
	localparam int unsigned RAD_BITS = 50;
	localparam int unsigned ROOT_BITS = RAD_BITS / 2;
	// Dividend 2^48, quotient up to 49 bits before saturation.
	localparam int unsigned QUO_BITS = 49;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TOUR = 1'b1;

	typedef struct packed {
		logic                     op;
		logic [CITY_BITS-1:0]     city;
		logic [IN_COORD_BITS-1:0] x_coord;
		logic [IN_COORD_BITS-1:0] y_coord;
		logic                     first_of_population;
		logic                     last_of_tour;
	} in_item_t;

	typedef struct packed {
		logic [LEN_BITS-1:0] tour_length;
		logic [FIT_BITS-1:0] fitness;
		logic [IDX_BITS-1:0] tour_index;
		logic                is_new_best;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_READ_A,
		ST_READ_B,
		ST_DIFF,
		ST_SQUARE,
		ST_SQRT_LOAD,
		ST_SQRT,
		ST_ACCUM,
		ST_DIV,
		ST_RESULT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;     // register the accepted transaction
		logic tour_setup;  // apply population reset and tour bookkeeping
		logic read_a;      // read store at the edge's first city
		logic read_b;      // read store at the edge's second city
		logic closing;     // the edge in work is the closing edge
		logic diff;
		logic square;
		logic sqrt_start;
		logic sqrt_step;
		logic accum;
		logic div_start;
		logic div_step;
		logic finish;      // write the result register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_load;
		logic is_last;
		logic is_start;    // first city of a tour: no edge
		logic sqrt_done;
		logic div_done;
	} status_t;

endpackage

/* rtl/core/tsp_datapath.sv */
// Datapath of the tour length unit: coordinate memory, square root and divider.
// Depends on tsp_pkg; driven by tsp_ctrl through tsp_pkg::cmd_t.
module tsp_datapath #(
	parameter int unsigned MAX_CITIES = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tsp_pkg::in_item_t  in_item,
	input  tsp_pkg::cmd_t      cmd,
	output tsp_pkg::status_t   status,
	output tsp_pkg::out_item_t result
);

	localparam int unsigned COORD_BITS = tsp_pkg::IN_COORD_BITS;
	localparam int unsigned ADDR_BITS = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
	localparam int unsigned SQ_BITS = 2 * COORD_BITS + 1;
	localparam int unsigned SQRT_STEPS = tsp_pkg::ROOT_BITS;
	localparam int unsigned DIV_STEPS = tsp_pkg::QUO_BITS;
	localparam logic [tsp_pkg::LEN_BITS-1:0] LEN_MAX = '1;
	localparam logic [tsp_pkg::FIT_BITS-1:0] FIT_MAX = '1;

	logic [2*COORD_BITS-1:0]        mem [MAX_CITIES];
	tsp_pkg::in_item_t              item_q;
	logic [tsp_pkg::CITY_BITS-1:0]  first_city_q;
	logic [tsp_pkg::CITY_BITS-1:0]  prev_city_q;
	logic                           in_tour_q;
	logic                           start_q;
	logic [tsp_pkg::LEN_BITS-1:0]   run_len_q;
	logic [tsp_pkg::FIT_BITS-1:0]   best_q;
	logic                           have_best_q;
	logic [tsp_pkg::IDX_BITS-1:0]   count_q;
	logic [2*COORD_BITS-1:0]        rd_q;
	logic                           rd_ok_q;
	logic [2*COORD_BITS-1:0]        pa_q;
	logic [2*COORD_BITS-1:0]        pb_q;
	logic [COORD_BITS-1:0]          dx_q;
	logic [COORD_BITS-1:0]          dy_q;
	logic [tsp_pkg::RAD_BITS-1:0]   rem_q;
	logic [tsp_pkg::RAD_BITS-1:0]   rad_q;
	logic [tsp_pkg::ROOT_BITS-1:0]  root_q;
	logic [$clog2(SQRT_STEPS+1)-1:0] sq_cnt_q;
	logic [tsp_pkg::LEN_BITS:0]     drem_q;
	logic [tsp_pkg::QUO_BITS-1:0]   quo_q;
	logic [$clog2(DIV_STEPS+1)-1:0] div_cnt_q;
	tsp_pkg::out_item_t             result_q;

	logic [tsp_pkg::CITY_BITS-1:0]  rd_city;
	logic [2*COORD_BITS-1:0]        rd_data;
	logic [tsp_pkg::RAD_BITS+1:0]   sq_trial;
	logic [tsp_pkg::RAD_BITS-1:0]   sq_rem_sh;
	logic [tsp_pkg::LEN_BITS+1:0]   len_sum;
	logic [tsp_pkg::LEN_BITS+1:0]   div_sh;
	logic [tsp_pkg::FIT_BITS-1:0]   fit;
	logic [COORD_BITS-1:0]          ax, ay, bx, by;

	// Capture the accepted transaction.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_item;
		end
	end

	// Coordinate memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.capture && in_item.op == tsp_pkg::OP_LOAD &&
				{1'b0, in_item.city} < (tsp_pkg::CITY_BITS+1)'(MAX_CITIES)) begin
			mem[in_item.city[ADDR_BITS-1:0]] <= {in_item.y_coord[COORD_BITS-1:0],
				in_item.x_coord[COORD_BITS-1:0]};
		end
		if (cmd.read_a || cmd.read_b) begin
			rd_q <= mem[rd_city[ADDR_BITS-1:0]];
		end
	end

	always_comb begin
		rd_city = cmd.read_a ? (cmd.closing ? item_q.city : prev_city_q)
			: (cmd.closing ? first_city_q : item_q.city);
	end

	// Out-of-range visits read as the origin.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ok_q <= 1'b0;
		end else if (cmd.read_a || cmd.read_b) begin
			rd_ok_q <= {1'b0, rd_city} < (tsp_pkg::CITY_BITS+1)'(MAX_CITIES);
		end
	end

	assign rd_data = rd_ok_q ? rd_q : '0;

	// Latch the two endpoints as they come out of the memory.
	always_ff @(posedge clk) begin
		if (cmd.read_b) begin
			pa_q <= rd_data;
		end
		if (cmd.diff) begin
			pb_q <= rd_data;
		end
	end

	always_comb begin
		ax = pa_q[COORD_BITS-1:0];
		ay = pa_q[2*COORD_BITS-1:COORD_BITS];
		bx = pb_q[COORD_BITS-1:0];
		by = pb_q[2*COORD_BITS-1:COORD_BITS];
	end

	// Absolute differences.
	always_ff @(posedge clk) begin
		if (cmd.square) begin
			dx_q <= (ax > bx) ? ax - bx : bx - ax;
			dy_q <= (ay > by) ? ay - by : by - ay;
		end
	end

	// Sum of squares scaled by 2^16, then a restoring square root two bits a step.
	assign sq_rem_sh = {rem_q[tsp_pkg::RAD_BITS-3:0], rad_q[tsp_pkg::RAD_BITS-1 -: 2]};
	assign sq_trial = {2'b00, sq_rem_sh} -
		{(tsp_pkg::RAD_BITS - tsp_pkg::ROOT_BITS)'(0), root_q, 2'b01};

	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			rad_q <= {(tsp_pkg::RAD_BITS-SQ_BITS-16)'(0),
				SQ_BITS'({COORD_BITS'(0), dx_q} * {COORD_BITS'(0), dx_q}) +
				SQ_BITS'({COORD_BITS'(0), dy_q} * {COORD_BITS'(0), dy_q}), 16'h0000};
			rem_q <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q <= {rad_q[tsp_pkg::RAD_BITS-3:0], 2'b00};
			if (!sq_trial[tsp_pkg::RAD_BITS+1]) begin
				rem_q <= sq_trial[tsp_pkg::RAD_BITS-1:0];
				root_q <= {root_q[tsp_pkg::ROOT_BITS-2:0], 1'b1};
			end else begin
				rem_q <= sq_rem_sh;
				root_q <= {root_q[tsp_pkg::ROOT_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_cnt_q <= '0;
		end else if (cmd.sqrt_start) begin
			sq_cnt_q <= '0;
		end else if (cmd.sqrt_step) begin
			sq_cnt_q <= sq_cnt_q + 1'b1;
		end
	end

	// Saturating accumulate of one edge.
	assign len_sum = {1'b0, run_len_q} +
		{(tsp_pkg::LEN_BITS+1-tsp_pkg::ROOT_BITS)'(0), root_q};

	// Tour bookkeeping, population state and running length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_city_q <= '0;
			prev_city_q <= '0;
			in_tour_q <= 1'b0;
			start_q <= 1'b0;
			run_len_q <= '0;
			best_q <= '0;
			have_best_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (cmd.tour_setup) begin
				if (item_q.first_of_population) begin
					have_best_q <= 1'b0;
					best_q <= '0;
					count_q <= '0;
				end
				start_q <= !in_tour_q;
				if (!in_tour_q) begin
					first_city_q <= item_q.city;
					prev_city_q <= item_q.city;
					run_len_q <= '0;
					in_tour_q <= 1'b1;
				end
			end
			if (cmd.accum) begin
				run_len_q <= len_sum[tsp_pkg::LEN_BITS] ? LEN_MAX
					: len_sum[tsp_pkg::LEN_BITS-1:0];
				if (!cmd.closing) begin
					prev_city_q <= item_q.city;
				end
			end
			if (cmd.div_start) begin
				prev_city_q <= item_q.city;
				in_tour_q <= !item_q.last_of_tour;
			end
			if (cmd.finish) begin
				count_q <= count_q + 1'b1;
				if (!have_best_q || fit > best_q) begin
					best_q <= fit;
					have_best_q <= 1'b1;
				end
			end
		end
	end

	// Restoring divider for 2^48 / length, one quotient bit a step.
	// The dividend's single one bit enters on the first step.
	assign div_sh = {drem_q, div_cnt_q == '0};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			drem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (div_sh >= {1'b0, run_len_q}) begin
				drem_q <= (tsp_pkg::LEN_BITS+1)'(div_sh - {1'b0, run_len_q});
				quo_q <= {quo_q[tsp_pkg::QUO_BITS-2:0], 1'b1};
			end else begin
				drem_q <= div_sh[tsp_pkg::LEN_BITS:0];
				quo_q <= {quo_q[tsp_pkg::QUO_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	// Saturate the quotient; zero length gives all ones as well.
	always_comb begin
		if (run_len_q == '0 || quo_q[tsp_pkg::QUO_BITS-1:tsp_pkg::FIT_BITS] != '0) begin
			fit = FIT_MAX;
		end else begin
			fit = quo_q[tsp_pkg::FIT_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q.tour_length <= run_len_q;
			result_q.fitness <= fit;
			result_q.tour_index <= count_q;
			result_q.is_new_best <= !have_best_q || fit > best_q;
		end
	end

	assign result = result_q;
	assign status.is_load = item_q.op == tsp_pkg::OP_LOAD;
	assign status.is_last = item_q.last_of_tour;
	assign status.is_start = start_q;
	assign status.sqrt_done = sq_cnt_q == ($clog2(SQRT_STEPS+1))'(SQRT_STEPS - 1);
	assign status.div_done = div_cnt_q == ($clog2(DIV_STEPS+1))'(DIV_STEPS - 1);

endmodule

/* rtl/core/tsp_ctrl.sv */
// Controller state machine of the tour length unit.
// Depends on tsp_pkg; commands tsp_datapath, owns both handshakes.
module tsp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  tsp_pkg::status_t status,
	output tsp_pkg::cmd_t    cmd
);

	tsp_pkg::state_t state_q, state_d;
	logic            closing_q;
	logic            out_valid_q;
	logic            out_free;

	// The result register is free when empty or being drained this cycle.
	assign out_free = !out_valid_q || out_ready;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tsp_pkg::ST_IDLE: begin
				if (in_valid) state_d = tsp_pkg::ST_SETUP;
			end
			tsp_pkg::ST_SETUP: begin
				state_d = status.is_load ? tsp_pkg::ST_IDLE : tsp_pkg::ST_READ_A;
			end
			tsp_pkg::ST_READ_A: begin
				if (status.is_start && !closing_q) begin
					state_d = status.is_last ? tsp_pkg::ST_READ_A : tsp_pkg::ST_IDLE;
				end else state_d = tsp_pkg::ST_READ_B;
			end
			tsp_pkg::ST_READ_B:    state_d = tsp_pkg::ST_DIFF;
			tsp_pkg::ST_DIFF:      state_d = tsp_pkg::ST_SQUARE;
			tsp_pkg::ST_SQUARE:    state_d = tsp_pkg::ST_SQRT_LOAD;
			tsp_pkg::ST_SQRT_LOAD: state_d = tsp_pkg::ST_SQRT;
			tsp_pkg::ST_SQRT: begin
				if (status.sqrt_done) state_d = tsp_pkg::ST_ACCUM;
			end
			tsp_pkg::ST_ACCUM: begin
				if (closing_q) state_d = tsp_pkg::ST_DIV;
				else if (status.is_last) state_d = tsp_pkg::ST_READ_A;
				else state_d = tsp_pkg::ST_IDLE;
			end
			tsp_pkg::ST_DIV: begin
				if (status.div_done) state_d = tsp_pkg::ST_RESULT;
			end
			tsp_pkg::ST_RESULT: begin
				if (out_free) state_d = tsp_pkg::ST_IDLE;
			end
			default: state_d = tsp_pkg::ST_IDLE;
		endcase
	end

	// Command decode.
	always_comb begin
		cmd = '0;
		cmd.closing = closing_q;
		unique case (state_q)
			tsp_pkg::ST_IDLE: begin
				cmd.capture = in_valid;
			end
			// Tour bookkeeping happens once, right after a tour transaction is captured.
			tsp_pkg::ST_SETUP: begin
				cmd.tour_setup = !status.is_load;
			end
			tsp_pkg::ST_READ_A: begin
				cmd.read_a = 1'b1;
			end
			tsp_pkg::ST_READ_B:    cmd.read_b = 1'b1;
			tsp_pkg::ST_DIFF:      cmd.diff = 1'b1;
			tsp_pkg::ST_SQUARE:    cmd.square = 1'b1;
			tsp_pkg::ST_SQRT_LOAD: cmd.sqrt_start = 1'b1;
			tsp_pkg::ST_SQRT:      cmd.sqrt_step = 1'b1;
			tsp_pkg::ST_ACCUM: begin
				cmd.accum = 1'b1;
				cmd.div_start = closing_q;
			end
			tsp_pkg::ST_DIV:    cmd.div_step = 1'b1;
			tsp_pkg::ST_RESULT: cmd.finish = out_free;
			default: cmd = '0;
		endcase
	end

	// State, closing-edge flag and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsp_pkg::ST_IDLE;
			closing_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == tsp_pkg::ST_IDLE) closing_q <= 1'b0;
			else if (state_q == tsp_pkg::ST_READ_A && state_d == tsp_pkg::ST_READ_A)
				closing_q <= 1'b1;
			else if (state_q == tsp_pkg::ST_ACCUM && state_d == tsp_pkg::ST_READ_A)
				closing_q <= 1'b1;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready = state_q == tsp_pkg::ST_IDLE;
	assign out_valid = out_valid_q;

endmodule

/* rtl/core/tsp_tour_length_fitness_unit.sv */
// Top level of the closed-tour length and fitness unit.
// Depends on tsp_pkg, tsp_ctrl and tsp_datapath.
//
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_ready   | tsp_pkg::in_item_t
// out     | output    | out_valid/out_ready | tsp_pkg::out_item_t
//
// A load passes through accept and setup. A tour city passes through accept, setup
// and, per edge, two reads, difference, square, root load, the 25-step square root
// loop and accumulate; a first city has no edge. The last city adds the closing
// edge, a 49-step divider and a result state. One transaction is in work at a
// time; the result state stalls while an earlier result waits, and the result
// register lets the next transaction enter meanwhile. Reset clears control
// state and the tour bookkeeping; the coordinate memory is undefined until loaded.
module tsp_tour_length_fitness_unit #(
	parameter int unsigned MAX_CITIES = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tsp_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output tsp_pkg::out_item_t out_data
);

	tsp_pkg::cmd_t    cmd;
	tsp_pkg::status_t status;

	tsp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .cmd(cmd)
	);

	tsp_datapath #(.MAX_CITIES(MAX_CITIES)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.in_item(in_data), .cmd(cmd),
		.status(status), .result(out_data)
	);

endmodule
